@@ rtl/core/single_float_add_sub_assert.svh @@
// Assertion macros used by the adder RTL.
`ifndef SINGLE_FLOAT_ADD_SUB_ASSERT_SVH
`define SINGLE_FLOAT_ADD_SUB_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/sfa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfa_pkg
// Constants shared by the single-precision adder.
// ----------------------------------------------------------------------------
package sfa_pkg;
  localparam int unsigned FracW = 23;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned WordW = 32;
  localparam logic [FracW-1:0] FracMask = 23'h7fffff;
  localparam logic [ExpW-1:0]  ExpMax   = 8'd254;
endpackage

@@ rtl/core/sfa_datapath.sv @@
// ----------------------------------------------------------------------------
// sfa_datapath
// Combinational align, add or subtract, normalize and truncate.
// ----------------------------------------------------------------------------
module sfa_datapath import sfa_pkg::*; #(
  parameter int unsigned KeptAlignBits = 8
) (
  input  logic             mode_i,
  input  logic [WordW-1:0] a_bits_i,
  input  logic [WordW-1:0] b_bits_i,
  output logic [WordW-1:0] result_bits_o,
  output logic             range_error_o
);
  localparam int unsigned MagW = 24 + KeptAlignBits + 1;
  localparam int unsigned PosW = $clog2(MagW);

  logic [WordW-1:0] b_eff;
  logic             sa, sb, sign;
  logic [7:0]       ea, eb, gap;
  logic             a_zero, b_zero, a_big;
  logic [MagW-1:0]  ma, mb, mag, norm;
  logic [9:0]       ework, rexp;
  logic [PosW-1:0]  p;
  logic [FracW-1:0] frac;

  always_comb begin
    b_eff = b_bits_i ^ {mode_i, 31'd0};
    sa = a_bits_i[31];
    sb = b_eff[31];
    ea = a_bits_i[30:23];
    eb = b_eff[30:23];
    a_zero = (a_bits_i[30:0] == '0);
    b_zero = (b_eff[30:0] == '0);
    ma = MagW'({1'b1, a_bits_i[22:0]});
    mb = MagW'({1'b1, b_eff[22:0]});
    a_big = (ea >= eb);
    gap = a_big ? (ea - eb) : (eb - ea);
    ework = {2'b00, a_big ? eb : ea};
    if (gap <= 8'(KeptAlignBits)) begin
      if (a_big) ma = ma << gap;
      else mb = mb << gap;
    end else begin
      // Large gap: the smaller operand is truncated by a right shift.
      ework = {2'b00, a_big ? ea : eb};
      if (a_big) mb = (gap >= 8'd32) ? '0 : (mb >> gap);
      else ma = (gap >= 8'd32) ? '0 : (ma >> gap);
    end
    if (sa == sb) begin
      mag = ma + mb;
      sign = sa;
    end else if (ma >= mb) begin
      mag = ma - mb;
      sign = sa;
    end else begin
      mag = mb - ma;
      sign = sb;
    end
    p = '0;
    for (int i = 0; i < MagW; i++) begin
      if (mag[i]) p = PosW'(i);
    end
    norm = mag << (PosW'(MagW - 1) - p);
    frac = norm[MagW-2 -: FracW];
    rexp = ework + 10'(p) - 10'd23;

    range_error_o = 1'b0;
    if (a_zero) begin
      result_bits_o = b_zero ? '0 : b_eff;
    end else if (b_zero) begin
      result_bits_o = a_bits_i;
    end else if (mag == '0) begin
      result_bits_o = '0;
    end else if (!rexp[9] && rexp > {2'b00, ExpMax}) begin
      range_error_o = 1'b1;
      result_bits_o = {sign, 8'hff, 23'd0};
    end else if (rexp[9] || rexp == '0) begin
      range_error_o = 1'b1;
      result_bits_o = {sign, 31'd0};
    end else begin
      result_bits_o = {sign, rexp[7:0], frac & FracMask};
    end
  end
endmodule

@@ rtl/core/single_float_add_sub.sv @@
// An accepted input beat is registered and its result shown the next cycle.
// Throughput: one beat per cycle while out_stall_i is low; the single-pass
// datapath sits between the input handshake and the result register.
// Reset: asynchronous, clears the output valid; the datapath holds no state.
// ----------------------------------------------------------------------------
// single_float_add_sub
// Truncating single-precision adder/subtractor with range flag.
// ----------------------------------------------------------------------------
`include "single_float_add_sub_assert.svh"
module single_float_add_sub import sfa_pkg::*; #(
  parameter int unsigned KEPT_ALIGN_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             mode_i,
  input  logic [WordW-1:0] a_bits_i,
  input  logic [WordW-1:0] b_bits_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] result_bits_o,
  output logic             range_error_o
);
  logic             valid_q;
  logic [WordW-1:0] res_q, res_d;
  logic             err_q, err_d;
  logic             load;

  sfa_datapath #(.KeptAlignBits(KEPT_ALIGN_BITS)) u_dp (
    .mode_i, .a_bits_i, .b_bits_i,
    .result_bits_o(res_d), .range_error_o(err_d)
  );

  assign in_stall_o = valid_q && out_stall_i;
  assign load = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
      err_q <= err_d;
    end
  end

  assign out_valid_o = valid_q;
  assign result_bits_o = res_q;
  assign range_error_o = err_q;

  `SFA_ASSERT_NEXT(a_load_valid, load, out_valid_o)
  `SFA_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_bits_o))
  `SFA_ASSERT_IMP(a_err_pattern, out_valid_o && range_error_o, result_bits_o[22:0] == '0)
endmodule

@@ tb/tb_single_float_add_sub.sv @@
// ----------------------------------------------------------------------------
// tb_single_float_add_sub
// Drives operand pairs into the truncating single-precision adder and checks
// each result beat against a predictor of the same arithmetic.
// ----------------------------------------------------------------------------
module tb_single_float_add_sub;
  timeunit 1ns;
  timeprecision 1ps;
  import sfa_pkg::*;

  localparam int unsigned KeptAlign = 8;
  localparam logic ModeAdd = 1'b0;
  localparam logic ModeSub = 1'b1;

  typedef struct packed {
    logic [31:0] bits;
    logic        range_err;
  } sum_t;

  int mismatch_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Truncating add or subtract, chosen by mode, of two single-precision words.
  function automatic sum_t float_sum(input logic mode, input logic [31:0] a,
                                     input logic [31:0] b_in);
    sum_t        r;
    logic [31:0] b;
    logic        sa, sb, sign;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic [63:0] ma, mb, mag;
    int          gap, ework, p, rexp;
    logic [22:0] frac;
    r = '0;
    b = b_in ^ {mode, 31'b0};
    sa = a[31]; sb = b[31];
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0]; fb = b[22:0];
    if (ea == 0 && fa == 0) begin
      r.bits = (eb == 0 && fb == 0) ? 32'h0 : b;
      return r;
    end
    if (eb == 0 && fb == 0) begin
      r.bits = a;
      return r;
    end
    ma = {40'b0, 1'b1, fa};
    mb = {40'b0, 1'b1, fb};
    if (ea >= eb) begin
      gap = ea - eb;
      if (gap <= KeptAlign) begin
        ma = ma << gap; ework = eb;
      end else begin
        mb = (gap >= 32) ? 64'h0 : mb >> gap; ework = ea;
      end
    end else begin
      gap = eb - ea;
      if (gap <= KeptAlign) begin
        mb = mb << gap; ework = ea;
      end else begin
        ma = (gap >= 32) ? 64'h0 : ma >> gap; ework = eb;
      end
    end
    if (sa == sb) begin
      mag = ma + mb; sign = sa;
    end else if (ma > mb) begin
      mag = ma - mb; sign = sa;
    end else if (mb > ma) begin
      mag = mb - ma; sign = sb;
    end else begin
      return r;
    end
    p = 0;
    for (int i = 63; i >= 0; i--) begin
      if (mag[i]) begin
        p = i;
        break;
      end
    end
    rexp = ework + p - 23;
    frac = (p >= 23) ? 23'(mag >> (p - 23)) : 23'(mag << (23 - p));
    if (rexp > 254) begin
      r.bits = {sign, 8'hff, 23'h0}; r.range_err = 1'b1;
    end else if (rexp < 1) begin
      r.bits = {sign, 31'h0}; r.range_err = 1'b1;
    end else begin
      r.bits = {sign, rexp[7:0], frac};
    end
    return r;
  endfunction

  class sum_scoreboard;
    sum_t pending_sums[$];

    function void note_operands(logic mode, logic [31:0] a, logic [31:0] b);
      pending_sums.push_back(float_sum(mode, a, b));
    endfunction

    task check_sum(logic [31:0] bits, logic range_err);
      sum_t want;
      if (pending_sums.size() == 0) begin
        report_mismatch("unexpected beat", bits, 32'h0);
        return;
      end
      want = pending_sums.pop_front();
      if (bits !== want.bits) report_mismatch("result_bits", bits, want.bits);
      if (range_err !== want.range_err)
        report_mismatch("range_error", 32'(range_err), 32'(want.range_err));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [31:0] a_bits_i = '0;
  logic [31:0] b_bits_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_bits_o;
  logic        range_error_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  sum_scoreboard sb = new();

  single_float_add_sub dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #4ms;
    $display("tb_single_float_add_sub: FAIL");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_sum(result_bits_o, range_error_o);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_beat(input logic mode, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    a_bits_i <= a;
    b_bits_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_operands(mode, a, b);
  endtask

  // Mostly normal-range operands with close exponents so the datapath works.
  function automatic logic [31:0] rand_operand();
    logic [31:0] v;
    int sel;
    sel = $urandom_range(9);
    v = $urandom();
    if (sel < 6) v[30:23] = 8'($urandom_range(110, 145));
    else if (sel == 6) v[30:0] = 31'h0;
    else if (sel == 7) v[30:23] = $urandom_range(1) ? 8'hff : 8'h00;
    return v;
  endfunction

  task automatic random_phase(input int n, input int idle, input int stall);
    logic [31:0] a, b;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) begin
      a = rand_operand();
      b = $urandom_range(3) == 0 ? rand_operand()
        : {1'($urandom()), 8'(int'(a[30:23]) + $signed(5'($urandom()))), 23'($urandom())};
      if ($urandom_range(7) == 0) b = a ^ {1'b1, 31'h0};
      send_beat(1'($urandom()), a, b);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_beat(ModeAdd, 32'h0, 32'h0);
    send_beat(ModeSub, 32'h8000_0000, 32'h3f80_0000);
    send_beat(ModeAdd, 32'h4040_0000, 32'h0);
    send_beat(ModeSub, 32'h3f80_0000, 32'h3f80_0000);
    send_beat(ModeAdd, 32'h3f80_0000, 32'hbf80_0000);
    send_beat(ModeAdd, 32'h7f7f_ffff, 32'h7f7f_ffff);
    send_beat(ModeAdd, 32'hff80_0000, 32'hff7f_ffff);
    send_beat(ModeSub, 32'h0080_0001, 32'h0080_0000);
    send_beat(ModeAdd, 32'h0000_0001, 32'h8000_0002);
    send_beat(ModeAdd, 32'h3f80_0000, 32'h3b80_0000);
    send_beat(ModeAdd, 32'h3f80_0000, 32'h3b00_0000);
    send_beat(ModeAdd, 32'h7fff_ffff, 32'h0000_0001);
    send_beat(ModeSub, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(ModeSub, 32'h4000_0000, 32'h3fff_ffff);
    send_beat(ModeAdd, 32'h5555_5555, 32'haaaa_aaaa);
    random_phase(100, 0, 0);
    random_phase(80, 83, 0);
    random_phase(80, 0, 83);
    random_phase(80, 26, 26);
    // Long receiver hold-off while the sender keeps offering beats.
    hold_off_cycles = 60;
    random_phase(40, 0, 0);
    random_phase(20, 0, 0);
    in_valid_i <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && !out_valid_o) begin
      $display("tb_single_float_add_sub: PASS");
    end else begin
      $display("tb_single_float_add_sub: FAIL");
    end
    $finish;
  end
endmodule
